### sv/path_smoothing_engine_unit_macros.svh
// assertion helpers shared by the smoothing engine rtl
`ifndef PATH_SMOOTHING_ENGINE_UNIT_MACROS_SVH
`define PATH_SMOOTHING_ENGINE_UNIT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define PSM_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that must hold in the cycle after the trigger
`define PSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/psm_pkg.sv
package psm_pkg;

    localparam int MAX_POINTS = 64;
    localparam int MAX_PASSES = 1024;
    localparam int FRAC_BITS  = 16;

    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int PASS_W     = $clog2(MAX_PASSES + 1);
    localparam int COORD_W    = 32;
    localparam int WEIGHT_W   = 16;
    localparam int SUM_W      = 40;
    localparam int MOVE_W     = COORD_W + 1;
    localparam int OUT_IDX_W  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TOL_W      = 32;

    localparam int ROUND_HALF = 1 << (WEIGHT_W - 1);

    // reset values of the configuration registers
    localparam logic [TOL_W-1:0]    TOL_RESET    = TOL_W'(((1 << FRAC_BITS) + 500) / 1000);
    localparam logic [WEIGHT_W-1:0] DWEIGHT_RESET = 16'd32768;
    localparam logic [WEIGHT_W-1:0] SWEIGHT_RESET = 16'd6554;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOLERANCE     = 2'd0,
        REG_DATA_WEIGHT   = 2'd1,
        REG_SMOOTH_WEIGHT = 2'd2
    } cfg_reg_t;

    // strobes that step one relaxation through the lane pipeline
    typedef struct packed {
        logic m1;
        logic a1;
        logic m2;
        logic a2;
    } psm_stage_t;

    // clamp a wide signed value to the coordinate range
    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [39:0] v);
        logic signed [39:0] hi;
        logic signed [39:0] lo;
        hi = 40'sd2147483647;
        lo = -40'sd2147483648;
        if (v > hi)
        begin
            return 32'sh7fffffff;
        end
        else if (v < lo)
        begin
            return 32'sh80000000;
        end
        return v[COORD_W-1:0];
    endfunction

endpackage

### sv/psm_if.sv
interface psm_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [psm_pkg::COORD_W-1:0]   point_x;
    logic signed [psm_pkg::COORD_W-1:0]   point_y;
    logic                                 is_fixed;
    logic                                 is_last_point;

    modport source (output valid, point_x, point_y, is_fixed, is_last_point, input ready);
    modport sink   (input valid, point_x, point_y, is_fixed, is_last_point, output ready);
endinterface

interface psm_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [psm_pkg::COORD_W-1:0]   out_x;
    logic signed [psm_pkg::COORD_W-1:0]   out_y;
    logic [psm_pkg::OUT_IDX_W-1:0]        out_index;
    logic                                 out_last;
    logic                                 converged;

    modport source (output valid, out_x, out_y, out_index, out_last, converged, input ready);
    modport sink   (input valid, out_x, out_y, out_index, out_last, converged, output ready);
endinterface

interface psm_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [psm_pkg::CFG_IDX_W-1:0]        idx;
    logic [psm_pkg::CFG_DATA_W-1:0]       wdata;

    modport source (output valid, idx, wdata, input ready);
    modport sink   (input valid, idx, wdata, output ready);
endinterface

### sv/psm_ram.sv
module psm_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // one registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/psm_lane.sv
module psm_lane (
    input  logic                                clk,
    input  psm_pkg::psm_stage_t                 stg,
    input  logic signed [psm_pkg::COORD_W-1:0]  cur,
    input  logic signed [psm_pkg::COORD_W-1:0]  orig,
    input  logic signed [psm_pkg::COORD_W-1:0]  prev,
    input  logic signed [psm_pkg::COORD_W-1:0]  nxt,
    input  logic [psm_pkg::WEIGHT_W-1:0]        data_weight,
    input  logic [psm_pkg::WEIGHT_W-1:0]        smooth_weight,
    output logic signed [psm_pkg::COORD_W-1:0]  result,
    output logic [psm_pkg::MOVE_W-1:0]          movement
);

    logic signed [32:0] d1;
    logic signed [16:0] w1;
    logic signed [16:0] w2;
    logic signed [49:0] p1_reg;
    logic signed [33:0] r1;
    logic signed [31:0] v1_reg;
    logic signed [34:0] d2;
    logic signed [51:0] p2_reg;
    logic signed [35:0] r2;
    logic signed [31:0] v2_reg;
    logic signed [32:0] diff;

    // pull toward the original point
    assign d1 = 33'(orig) - 33'(cur);
    assign w1 = $signed({1'b0, data_weight});
    assign r1 = 34'((p1_reg + 50'(psm_pkg::ROUND_HALF)) >>> psm_pkg::WEIGHT_W);

    // pull toward the neighbor mean, previous neighbor already updated
    assign d2 = 35'(prev) + 35'(nxt) - (35'(v1_reg) <<< 1);
    assign w2 = $signed({1'b0, smooth_weight});
    assign r2 = 36'((p2_reg + 52'(psm_pkg::ROUND_HALF)) >>> psm_pkg::WEIGHT_W);

    always_ff @(posedge clk)
    begin
        if (stg.m1)
        begin
            p1_reg <= d1 * w1;
        end
        if (stg.a1)
        begin
            v1_reg <= psm_pkg::sat32(40'(cur) + 40'(r1));
        end
        if (stg.m2)
        begin
            p2_reg <= d2 * w2;
        end
        if (stg.a2)
        begin
            v2_reg <= psm_pkg::sat32(40'(v1_reg) + 40'(r2));
        end
    end

    // absolute movement of this coordinate
    assign diff     = 33'(cur) - 33'(v2_reg);
    assign movement = diff[32] ? $unsigned(-diff) : $unsigned(diff);
    assign result   = v2_reg;

endmodule

### sv/path_smoothing_engine_unit.sv
// path smoothing engine
// in_ch takes route points (point_x, point_y, is_fixed, is_last_point) one per
// cycle while the block is loading. up to MAX_POINTS points are stored; later
// points are dropped but their last mark still starts smoothing.
// after the last point the block runs passes over the stored route until the
// summed movement of a pass is below tolerance or MAX_PASSES passes have run.
// a pass reads the first two points, then for each interior point its next
// neighbor and original; a moved point runs the two lane multiply-add steps and a
// write back, a fixed point only slides the window; fewer than three points skip
// to evaluation. then every stored point leaves on out_ch one at a time, with
// out_index, out_last and converged; the next is read only after the sink takes
// the current one. a stalled sink holds it in the output register; in_ch stays
// not ready until the last result is taken. the cfg channel is always ready and
// writes tolerance, data_weight and smooth_weight; write it only while idle.
// reset (rst_n low) empties the route and restores the register defaults.
// point memories need no clearing: only written entries are read.
module path_smoothing_engine_unit (
    input  logic            clk,
    input  logic            rst_n,
    psm_in_if.sink          in_ch,
    psm_out_if.source       out_ch,
    psm_cfg_if.sink         cfg
);

    `include "path_smoothing_engine_unit_macros.svh"

    localparam int CW = psm_pkg::COORD_W;

    typedef enum logic [3:0] {
        ST_LOAD, ST_START, ST_PREV, ST_CUR, ST_RD, ST_GET, ST_M1, ST_A1,
        ST_M2, ST_A2, ST_WB, ST_EVAL, ST_ORD, ST_OCAP, ST_OSHOW
    } state_t;

    state_t                          state_reg;
    logic [psm_pkg::CNT_W-1:0]       count_reg;
    logic [psm_pkg::IDX_W-1:0]       i_reg;
    logic [psm_pkg::IDX_W-1:0]       j_reg;
    logic [psm_pkg::PASS_W-1:0]      pass_reg;
    logic [psm_pkg::SUM_W-1:0]       sum_reg;
    logic [psm_pkg::TOL_W-1:0]       tol_reg;
    logic [psm_pkg::WEIGHT_W-1:0]    dw_reg;
    logic [psm_pkg::WEIGHT_W-1:0]    sw_reg;
    logic                            conv_reg;
    logic signed [CW-1:0]            prev_x_reg, prev_y_reg, cur_x_reg, cur_y_reg;
    logic signed [CW-1:0]            next_x_reg, next_y_reg, orig_x_reg, orig_y_reg;
    logic signed [CW-1:0]            out_x_reg, out_y_reg;
    logic                            out_last_reg;

    logic                            in_acc;
    logic                            out_acc;
    logic                            cfg_acc;
    logic                            sm_we, sm_re, or_we, or_re;
    logic [psm_pkg::IDX_W-1:0]       sm_waddr, sm_raddr, or_waddr;
    logic [2*CW-1:0]                 sm_wdata, sm_rdata;
    logic [2*CW:0]                   or_wdata, or_rdata;
    logic signed [CW-1:0]            sm_rx, sm_ry;
    logic                            more_points;
    logic                            last_out;
    psm_pkg::psm_stage_t             stg;
    logic signed [CW-1:0]            new_x, new_y;
    logic [psm_pkg::MOVE_W-1:0]      mv_x, mv_y;
    logic [psm_pkg::SUM_W:0]         sum_add;

    assign in_acc  = in_ch.valid && in_ch.ready;
    assign out_acc = out_ch.valid && out_ch.ready;
    assign cfg_acc = cfg.valid && cfg.ready;

    assign in_ch.ready = (state_reg == ST_LOAD);
    assign cfg.ready   = 1'b1;

    assign sm_rx = sm_rdata[CW-1:0];
    assign sm_ry = sm_rdata[2*CW-1:CW];

    // another interior point follows the current one
    assign more_points = (psm_pkg::CNT_W'(i_reg) + psm_pkg::CNT_W'(2)) < count_reg;
    assign last_out    = (psm_pkg::CNT_W'(j_reg) + psm_pkg::CNT_W'(1)) == count_reg;

    // memory port control
    always_comb
    begin
        sm_we    = 1'b0;
        or_we    = 1'b0;
        sm_waddr = i_reg;
        or_waddr = count_reg[psm_pkg::IDX_W-1:0];
        sm_wdata = {new_y, new_x};
        or_wdata = {in_ch.is_fixed, in_ch.point_y, in_ch.point_x};
        sm_re    = 1'b0;
        or_re    = 1'b0;
        sm_raddr = i_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && (count_reg < psm_pkg::CNT_W'(psm_pkg::MAX_POINTS)))
                begin
                    sm_we    = 1'b1;
                    or_we    = 1'b1;
                    sm_waddr = count_reg[psm_pkg::IDX_W-1:0];
                    sm_wdata = {in_ch.point_y, in_ch.point_x};
                end
            end
            ST_START:
            begin
                sm_re    = 1'b1;
                sm_raddr = '0;
            end
            ST_PREV:
            begin
                sm_re    = 1'b1;
                sm_raddr = psm_pkg::IDX_W'(1);
            end
            ST_RD:
            begin
                sm_re    = 1'b1;
                or_re    = 1'b1;
                sm_raddr = i_reg + psm_pkg::IDX_W'(1);
            end
            ST_WB:
            begin
                sm_we = 1'b1;
            end
            ST_ORD:
            begin
                sm_re    = 1'b1;
                sm_raddr = j_reg;
            end
            default:
            begin
                sm_we = 1'b0;
            end
        endcase
    end

    // lane pipeline strobes
    assign stg.m1 = (state_reg == ST_M1);
    assign stg.a1 = (state_reg == ST_A1);
    assign stg.m2 = (state_reg == ST_M2);
    assign stg.a2 = (state_reg == ST_A2);

    psm_ram #(.WIDTH(2*CW), .DEPTH(psm_pkg::MAX_POINTS)) u_smooth_ram (
        .clk   (clk),
        .we    (sm_we),
        .waddr (sm_waddr),
        .wdata (sm_wdata),
        .re    (sm_re),
        .raddr (sm_raddr),
        .rdata (sm_rdata)
    );

    psm_ram #(.WIDTH(2*CW+1), .DEPTH(psm_pkg::MAX_POINTS)) u_orig_ram (
        .clk   (clk),
        .we    (or_we),
        .waddr (or_waddr),
        .wdata (or_wdata),
        .re    (or_re),
        .raddr (i_reg),
        .rdata (or_rdata)
    );

    psm_lane u_lane_x (
        .clk           (clk),
        .stg           (stg),
        .cur           (cur_x_reg),
        .orig          (orig_x_reg),
        .prev          (prev_x_reg),
        .nxt           (next_x_reg),
        .data_weight   (dw_reg),
        .smooth_weight (sw_reg),
        .result        (new_x),
        .movement      (mv_x)
    );

    psm_lane u_lane_y (
        .clk           (clk),
        .stg           (stg),
        .cur           (cur_y_reg),
        .orig          (orig_y_reg),
        .prev          (prev_y_reg),
        .nxt           (next_y_reg),
        .data_weight   (dw_reg),
        .smooth_weight (sw_reg),
        .result        (new_y),
        .movement      (mv_y)
    );

    // pass movement accumulation
    assign sum_add = (psm_pkg::SUM_W+1)'(sum_reg) + (psm_pkg::SUM_W+1)'(mv_x)
                   + (psm_pkg::SUM_W+1)'(mv_y);

    // sequencer, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            pass_reg     <= '0;
            sum_reg      <= '0;
            conv_reg     <= 1'b0;
            out_last_reg <= 1'b0;
            tol_reg      <= psm_pkg::TOL_RESET;
            dw_reg       <= psm_pkg::DWEIGHT_RESET;
            sw_reg       <= psm_pkg::SWEIGHT_RESET;
        end
        else
        begin
            if (cfg_acc)
            begin
                case (psm_pkg::cfg_reg_t'(cfg.idx))
                    psm_pkg::REG_TOLERANCE:     tol_reg <= cfg.wdata;
                    psm_pkg::REG_DATA_WEIGHT:   dw_reg  <= cfg.wdata[psm_pkg::WEIGHT_W-1:0];
                    psm_pkg::REG_SMOOTH_WEIGHT: sw_reg  <= cfg.wdata[psm_pkg::WEIGHT_W-1:0];
                    default:                    tol_reg <= tol_reg;
                endcase
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (count_reg < psm_pkg::CNT_W'(psm_pkg::MAX_POINTS))
                        begin
                            count_reg <= count_reg + psm_pkg::CNT_W'(1);
                        end
                        if (in_ch.is_last_point)
                        begin
                            pass_reg  <= '0;
                            state_reg <= ST_START;
                        end
                    end
                end
                ST_START:
                begin
                    sum_reg <= '0;
                    i_reg   <= psm_pkg::IDX_W'(1);
                    if (count_reg < psm_pkg::CNT_W'(3))
                    begin
                        state_reg <= ST_EVAL;
                    end
                    else
                    begin
                        state_reg <= ST_PREV;
                    end
                end
                ST_PREV:
                begin
                    prev_x_reg <= sm_rx;
                    prev_y_reg <= sm_ry;
                    state_reg  <= ST_CUR;
                end
                ST_CUR:
                begin
                    cur_x_reg <= sm_rx;
                    cur_y_reg <= sm_ry;
                    state_reg <= ST_RD;
                end
                ST_RD:
                begin
                    state_reg <= ST_GET;
                end
                ST_GET:
                begin
                    if (or_rdata[2*CW])
                    begin
                        // fixed point: just slide the window
                        prev_x_reg <= cur_x_reg;
                        prev_y_reg <= cur_y_reg;
                        cur_x_reg  <= sm_rx;
                        cur_y_reg  <= sm_ry;
                        i_reg      <= i_reg + psm_pkg::IDX_W'(1);
                        state_reg  <= more_points ? ST_RD : ST_EVAL;
                    end
                    else
                    begin
                        next_x_reg <= sm_rx;
                        next_y_reg <= sm_ry;
                        orig_x_reg <= or_rdata[CW-1:0];
                        orig_y_reg <= or_rdata[2*CW-1:CW];
                        state_reg  <= ST_M1;
                    end
                end
                ST_M1:
                begin
                    state_reg <= ST_A1;
                end
                ST_A1:
                begin
                    state_reg <= ST_M2;
                end
                ST_M2:
                begin
                    state_reg <= ST_A2;
                end
                ST_A2:
                begin
                    state_reg <= ST_WB;
                end
                ST_WB:
                begin
                    sum_reg    <= sum_add[psm_pkg::SUM_W] ? '1 : sum_add[psm_pkg::SUM_W-1:0];
                    prev_x_reg <= new_x;
                    prev_y_reg <= new_y;
                    cur_x_reg  <= next_x_reg;
                    cur_y_reg  <= next_y_reg;
                    i_reg      <= i_reg + psm_pkg::IDX_W'(1);
                    state_reg  <= more_points ? ST_RD : ST_EVAL;
                end
                ST_EVAL:
                begin
                    j_reg <= '0;
                    if (sum_reg < psm_pkg::SUM_W'(tol_reg))
                    begin
                        conv_reg  <= 1'b1;
                        state_reg <= ST_ORD;
                    end
                    else if ((pass_reg + psm_pkg::PASS_W'(1))
                             >= psm_pkg::PASS_W'(psm_pkg::MAX_PASSES))
                    begin
                        conv_reg  <= 1'b0;
                        state_reg <= ST_ORD;
                    end
                    else
                    begin
                        pass_reg  <= pass_reg + psm_pkg::PASS_W'(1);
                        state_reg <= ST_START;
                    end
                end
                ST_ORD:
                begin
                    state_reg <= ST_OCAP;
                end
                ST_OCAP:
                begin
                    out_x_reg    <= sm_rx;
                    out_y_reg    <= sm_ry;
                    out_last_reg <= last_out;
                    state_reg    <= ST_OSHOW;
                end
                ST_OSHOW:
                begin
                    if (out_acc)
                    begin
                        if (out_last_reg)
                        begin
                            count_reg <= '0;
                            pass_reg  <= '0;
                            sum_reg   <= '0;
                            state_reg <= ST_LOAD;
                        end
                        else
                        begin
                            j_reg     <= j_reg + psm_pkg::IDX_W'(1);
                            state_reg <= ST_ORD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    // result channel
    assign out_ch.valid     = (state_reg == ST_OSHOW);
    assign out_ch.out_x     = out_x_reg;
    assign out_ch.out_y     = out_y_reg;
    assign out_ch.out_index = psm_pkg::OUT_IDX_W'(j_reg);
    assign out_ch.out_last  = out_last_reg;
    assign out_ch.converged = conv_reg;

    // checks
    `PSM_ASSERT_NOW(a_no_load_during_emit, !(in_ch.ready && out_ch.valid),
        "input taken while results are pending")
    `PSM_ASSERT_NOW(a_pass_limit, pass_reg < psm_pkg::PASS_W'(psm_pkg::MAX_PASSES),
        "pass counter beyond pass limit")
    `PSM_ASSERT_NOW(a_window_in_route, (state_reg != ST_RD)
        || ((psm_pkg::CNT_W'(i_reg) + psm_pkg::CNT_W'(1)) < count_reg),
        "neighbor read beyond stored route")
    `PSM_ASSERT_NEXT(a_route_done, out_acc && out_ch.out_last,
        (count_reg == '0) && in_ch.ready, "route not released after last result")

endmodule
